// ----- src/ralp_pkg.sv -----
// ----------------------------------------------------------------------------
// ralp_pkg
// Shared widths, constants, codes and helpers for the line position block.
// ----------------------------------------------------------------------------
package ralp_pkg;

   localparam int MAX_SENSORS = 32;

   localparam int IDX_W   = 5;
   localparam int RAW_W   = 10;
   localparam int CNT_W   = 6;
   localparam int NORM_W  = 10;
   localparam int POS_W   = 15;
   localparam int PROD_W  = 25;
   localparam int WSUM_W  = 30;
   localparam int LSUM_W  = 15;
   localparam int QUO_W   = 30;
   localparam int DVS_W   = 15;
   localparam int SCALE_W = 20;
   localparam int STEP_W  = 5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_IS_BLACK = 2'd2;

   localparam logic [RAW_W-1:0]  RAW_MAX       = 10'd1023;
   localparam logic [NORM_W-1:0] NORM_MAX      = 10'd1000;
   localparam logic [NORM_W-1:0] SEEN_LEVEL    = 10'd200;
   localparam logic [NORM_W-1:0] NOISE_LEVEL   = 10'd50;
   localparam logic [POS_W-1:0]  POS_MAX       = 15'd31000;
   localparam logic [WSUM_W-1:0] WSUM_MAX      = '1;
   localparam logic [LSUM_W-1:0] LSUM_MAX      = '1;

   localparam logic [CNT_W-1:0]  COUNT_RESET     = 6'd8;
   localparam logic [NORM_W-1:0] THRESHOLD_RESET = 10'd500;

   localparam logic [STEP_W-1:0] NORM_STEPS = 5'd20;
   localparam logic [STEP_W-1:0] POS_STEPS  = 5'd30;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL  = 9'b000000010,
      S_DIV  = 9'b000000100,
      S_NORM = 9'b000001000,
      S_WMUL = 9'b000010000,
      S_ACC  = 9'b000100000,
      S_POS  = 9'b001000000,
      S_PFIN = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   // sensor index times 1000
   function automatic logic [POS_W-1:0] weight(input logic [IDX_W-1:0] k);
      weight = POS_W'(k) * POS_W'(1000);
   endfunction

endpackage

// ----- src/reflectance_array_line_position.sv -----
// ----------------------------------------------------------------------------
// reflectance_array_line_position
// Per-sensor calibration, normalization to 0..1000 and weighted line position.
// A calibration sample is taken without leaving the idle state and gives no
// result. A measurement sample is loaded and scaled, then runs one quotient
// bit per cycle through a shared serial divider (20 steps), then is
// weighted, accumulated and handed off. When the calibrated range is empty
// or the reading is at or below the minimum, the divider is skipped. The
// sample marked last also computes the position, through 30 more divider
// steps when the line was seen, or without the divider when it was not.
// The hand-off waits while an earlier result is held by a stalled output.
// The input is stalled while a sample is in progress; a finished result
// sits in an output register while the next sample is taken.
// ----------------------------------------------------------------------------
module reflectance_array_line_position (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [ralp_pkg::IDX_W-1:0]          req_sensor_index,
   input  logic [ralp_pkg::RAW_W-1:0]          req_raw,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ralp_pkg::NORM_W-1:0]         rsp_normalized,
   output logic                                rsp_on_bit,
   output logic [ralp_pkg::POS_W-1:0]          rsp_position,
   output logic                                rsp_position_valid,
   output logic                                rsp_line_seen,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ralp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ralp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import ralp_pkg::*;

   state_type state_ff, state_in;

   logic [RAW_W-1:0]  cal_min_ff [MAX_SENSORS];
   logic [RAW_W-1:0]  cal_max_ff [MAX_SENSORS];

   logic [CNT_W-1:0]  sensor_count_ff, sensor_count_in;
   logic [NORM_W-1:0] threshold_ff, threshold_in;
   logic              line_is_black_ff, line_is_black_in;

   logic              last_ff, last_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic [RAW_W-1:0]  lo_ff, lo_in;
   logic [RAW_W-1:0]  hi_ff, hi_in;

   logic [QUO_W-1:0]  q_ff, q_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              div_pos_ff, div_pos_in;

   logic [NORM_W-1:0] n_ff, n_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [LSUM_W-1:0] lsum_ff, lsum_in;
   logic              seen_ff, seen_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  rem_pos_ff, rem_pos_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NORM_W-1:0] rsp_norm_ff, rsp_norm_in;
   logic              rsp_on_ff, rsp_on_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_pvalid_ff, rsp_pvalid_in;
   logic              rsp_seen_ff, rsp_seen_in;

   logic              cal_we;
   logic [RAW_W-1:0]  cal_min_in, cal_max_in;

   logic              req_xfer, rsp_xfer, idx_ok;
   logic [RAW_W-1:0]  rd_min, rd_max, diff;
   logic [DVS_W:0]    trial;
   logic              trial_ge;
   logic [SCALE_W-1:0] quo_norm;
   logic [NORM_W-1:0] n_clamp;
   logic [WSUM_W:0]   wsum_sum;
   logic [LSUM_W:0]   lsum_sum;
   logic [IDX_W-1:0]  far_idx;
   logic [POS_W-1:0]  far_pos;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   assign idx_ok = (int'(req_sensor_index) < MAX_SENSORS);
   assign rd_min = idx_ok ? cal_min_ff[req_sensor_index] : RAW_MAX;
   assign rd_max = idx_ok ? cal_max_ff[req_sensor_index] : '0;

   assign diff     = raw_ff - lo_ff;
   assign trial    = {rem_ff, q_ff[QUO_W-1]} - {1'b0, dvs_ff};
   assign trial_ge = !trial[DVS_W];
   assign quo_norm = q_ff[SCALE_W-1:0];
   assign n_clamp  = (quo_norm > SCALE_W'(NORM_MAX)) ? NORM_MAX : quo_norm[NORM_W-1:0];
   assign wsum_sum = {1'b0, wsum_ff} + (WSUM_W+1)'(prod_ff);
   assign lsum_sum = {1'b0, lsum_ff} + (LSUM_W+1)'(n_ff);

   always_comb begin
      if (sensor_count_ff == '0) begin
         far_idx = '0;
      end else if (int'(sensor_count_ff) > MAX_SENSORS) begin
         far_idx = IDX_W'(MAX_SENSORS - 1);
      end else begin
         far_idx = IDX_W'(sensor_count_ff - CNT_W'(1));
      end
   end
   assign far_pos = weight(far_idx);

   always_comb begin
      state_in         = state_ff;
      sensor_count_in  = sensor_count_ff;
      threshold_in     = threshold_ff;
      line_is_black_in = line_is_black_ff;
      last_in          = last_ff;
      idx_in           = idx_ff;
      raw_in           = raw_ff;
      lo_in            = lo_ff;
      hi_in            = hi_ff;
      q_in             = q_ff;
      rem_in           = rem_ff;
      dvs_in           = dvs_ff;
      step_in          = step_ff;
      div_pos_in       = div_pos_ff;
      n_in             = n_ff;
      prod_in          = prod_ff;
      wsum_in          = wsum_ff;
      lsum_in          = lsum_ff;
      seen_in          = seen_ff;
      pos_in           = pos_ff;
      rem_pos_in       = rem_pos_ff;
      rsp_valid_in     = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_norm_in      = rsp_norm_ff;
      rsp_on_in        = rsp_on_ff;
      rsp_pos_in       = rsp_pos_ff;
      rsp_pvalid_in    = rsp_pvalid_ff;
      rsp_seen_in      = rsp_seen_ff;
      cal_we           = 1'b0;
      cal_min_in       = (req_raw < rd_min) ? req_raw : rd_min;
      cal_max_in       = (req_raw > rd_max) ? req_raw : rd_max;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SENSOR_COUNT:  sensor_count_in  = csr_data[CNT_W-1:0];
            CSR_THRESHOLD:     threshold_in     = csr_data[NORM_W-1:0];
            CSR_LINE_IS_BLACK: line_is_black_in = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (!req_kind) begin
                  cal_we = idx_ok;
               end else begin
                  idx_in   = req_sensor_index;
                  raw_in   = req_raw;
                  last_in  = req_last;
                  lo_in    = rd_min;
                  hi_in    = rd_max;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            rem_in     = '0;
            div_pos_in = 1'b0;
            if (hi_ff > lo_ff && raw_ff > lo_ff) begin
               q_in     = {SCALE_W'(diff) * SCALE_W'(NORM_MAX), (QUO_W-SCALE_W)'(0)};
               dvs_in   = DVS_W'(hi_ff - lo_ff);
               step_in  = NORM_STEPS;
               state_in = S_DIV;
            end else begin
               q_in     = '0;
               state_in = S_NORM;
            end
         end
         S_DIV: begin
            q_in    = {q_ff[QUO_W-2:0], trial_ge};
            rem_in  = trial_ge ? trial[DVS_W-1:0] : {rem_ff[DVS_W-2:0], q_ff[QUO_W-1]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = div_pos_ff ? S_PFIN : S_NORM;
            end
         end
         S_NORM: begin
            n_in = line_is_black_ff ? n_clamp : NORM_MAX - n_clamp;
            if ((line_is_black_ff ? n_clamp : NORM_MAX - n_clamp) > SEEN_LEVEL) begin
               seen_in = 1'b1;
            end
            state_in = S_WMUL;
         end
         S_WMUL: begin
            prod_in  = PROD_W'(n_ff) * PROD_W'(weight(idx_ff));
            state_in = S_ACC;
         end
         S_ACC: begin
            if (n_ff > NOISE_LEVEL) begin
               wsum_in = (wsum_sum > (WSUM_W+1)'(WSUM_MAX)) ? WSUM_MAX
                                                             : wsum_sum[WSUM_W-1:0];
               lsum_in = (lsum_sum > (LSUM_W+1)'(LSUM_MAX)) ? LSUM_MAX
                                                             : lsum_sum[LSUM_W-1:0];
            end
            state_in = last_ff ? S_POS : S_DONE;
         end
         S_POS: begin
            if (!seen_ff) begin
               pos_in   = (rem_pos_ff < (far_pos >> 1)) ? '0 : far_pos;
               state_in = S_DONE;
            end else if (lsum_ff == '0) begin
               pos_in     = '0;
               rem_pos_in = '0;
               state_in   = S_DONE;
            end else begin
               q_in       = QUO_W'(wsum_ff);
               rem_in     = '0;
               dvs_in     = DVS_W'(lsum_ff);
               step_in    = POS_STEPS;
               div_pos_in = 1'b1;
               state_in   = S_DIV;
            end
         end
         S_PFIN: begin
            pos_in     = (q_ff > QUO_W'(POS_MAX)) ? POS_MAX : q_ff[POS_W-1:0];
            rem_pos_in = (q_ff > QUO_W'(POS_MAX)) ? POS_MAX : q_ff[POS_W-1:0];
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_norm_in   = n_ff;
               rsp_on_in     = (n_ff > threshold_ff);
               rsp_pos_in    = last_ff ? pos_ff : '0;
               rsp_pvalid_in = last_ff;
               rsp_seen_in   = last_ff && seen_ff;
               if (last_ff) begin
                  wsum_in = '0;
                  lsum_in = '0;
                  seen_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         sensor_count_ff  <= COUNT_RESET;
         threshold_ff     <= THRESHOLD_RESET;
         line_is_black_ff <= 1'b1;
         wsum_ff          <= '0;
         lsum_ff          <= '0;
         seen_ff          <= 1'b0;
         rem_pos_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < MAX_SENSORS; i++) begin
            cal_min_ff[i] <= RAW_MAX;
            cal_max_ff[i] <= '0;
         end
      end else begin
         state_ff         <= state_in;
         sensor_count_ff  <= sensor_count_in;
         threshold_ff     <= threshold_in;
         line_is_black_ff <= line_is_black_in;
         wsum_ff          <= wsum_in;
         lsum_ff          <= lsum_in;
         seen_ff          <= seen_in;
         rem_pos_ff       <= rem_pos_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (cal_we) begin
            cal_min_ff[req_sensor_index] <= cal_min_in;
            cal_max_ff[req_sensor_index] <= cal_max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      raw_ff        <= raw_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      step_ff       <= step_in;
      div_pos_ff    <= div_pos_in;
      n_ff          <= n_in;
      prod_ff       <= prod_in;
      pos_ff        <= pos_in;
      rsp_norm_ff   <= rsp_norm_in;
      rsp_on_ff     <= rsp_on_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_seen_ff   <= rsp_seen_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_normalized     = rsp_norm_ff;
   assign rsp_on_bit         = rsp_on_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_position_valid = rsp_pvalid_ff;
   assign rsp_line_seen      = rsp_seen_ff;

endmodule

// ----- src/ralp_checker.sv -----
// ----------------------------------------------------------------------------
// ralp_checker
// Port-level checks for the line position block, bound to the top level.
// ----------------------------------------------------------------------------
module ralp_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_kind,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [ralp_pkg::NORM_W-1:0]         rsp_normalized,
   input  logic [ralp_pkg::POS_W-1:0]          rsp_position,
   input  logic                                rsp_position_valid,
   input  logic                                rsp_line_seen
);
   import ralp_pkg::*;

   // a measurement transfer keeps the input stalled while it is worked on
   a_busy_after_measure: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind |=> req_stall)
      else $error("input not stalled after measurement transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normalized)
                                 && $stable(rsp_position))
      else $error("stalled result changed");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normalized <= NORM_MAX && rsp_position <= POS_MAX)
      else $error("result out of range");

   a_pos_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_position_valid |-> rsp_position == '0 && !rsp_line_seen)
      else $error("position fields set on a mid-sweep result");

endmodule

bind reflectance_array_line_position ralp_checker u_ralp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_kind           (req_kind),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_normalized     (rsp_normalized),
   .rsp_position       (rsp_position),
   .rsp_position_valid (rsp_position_valid),
   .rsp_line_seen      (rsp_line_seen)
);
